// ===== src/pjlm_pkg.sv =====
package pjlm_pkg;

    localparam int TIME_W   = 48;
    localparam int EXP_W    = 16;
    localparam int PCNT_W   = 11;
    localparam int JIT_W    = 40;
    localparam int LOSS_W   = 15;
    localparam int DEV_W    = 32;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PING_COUNT        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_ENABLE       = 2'd2;

    localparam logic [EXP_W-1:0]  RST_EXPECTED_INTERVAL = 16'd100;
    localparam logic [PCNT_W-1:0] RST_PING_COUNT        = 11'd100;
    localparam logic              RST_LOSS_ENABLE       = 1'b1;

    localparam logic [LOSS_W-1:0] LOSS_FULL_SCALE = 15'd25600;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// ===== src/pjlm_div.sv =====
module pjlm_div #(
    parameter int DW = 51,
    parameter int VW = 11
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [DW-1:0]          i_dividend,
    input  logic [VW-1:0]          i_divisor,
    output logic [DW-1:0]          o_quotient,
    output pjlm_pkg::t_div_status  o_status
);
    import pjlm_pkg::*;

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    r_num, n_num;
    logic [VW-1:0]    r_rem, n_rem;
    logic [VW-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [VW:0]      w_trial;
    logic [VW:0]      w_diff;
    logic             w_ge;

    always_comb begin
        w_trial = {r_rem, r_num[DW-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_diff  = w_trial - {1'b0, r_div};
        n_rem   = w_ge ? w_diff[VW-1:0] : w_trial[VW-1:0];
        n_num   = {r_num[DW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_quotient    = r_num;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

// ===== src/ping_jitter_loss_meter_unit.sv =====
// Ping jitter and loss meter. Each input transaction is one ping slot: tuser is the received
// flag, tdata the 48-bit receive time in ms, tlast ends the measurement after this slot.
// After the first reception every received ping adds |gap - expected_interval| (saturated
// at 2^32-1) to a running sum; a lost slot advances the held time by expected_interval.
// When ping_count slots have passed, or tlast is seen, one result is sent: tdata holds the
// mean deviation (40 bits, 8 fraction bits, rounded) and the loss percentage of ping_count
// (15 bits, 8 fraction bits, rounded, zero when loss_enable is 0); tuser flags that no
// deviation sample was formed. After a slot is accepted, s_axis_tready stays low while the
// sequencer steps the states S_GAP, S_END (lost slot), S_GAP, S_ACC, S_END (first received
// ping) or S_GAP, S_DEV, S_ACC, S_END (later received ping), sharing one absolute-difference
// unit between S_GAP and S_DEV. A closing slot then steps S_DJ, S_DJW, S_DL, S_DLW and S_OUT:
// up to two passes through the bit-serial divider, one quotient bit per cycle, and the load
// of the output register in S_OUT, which waits while that register still holds a result not
// yet taken. A finished result is held in the output register while new slots are taken.
module ping_jitter_loss_meter_unit #(
    parameter int MAX_PINGS = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [pjlm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [47:0] rx_time_ms
    input  logic                                 s_axis_tuser,  // [0] received
    input  logic                                 s_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [39:0] jitter_mean_q8, [54:40] loss_percent_q8, [55] zero
    output logic [pjlm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tuser,  // [0] no_samples
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pjlm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pjlm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import pjlm_pkg::*;

    localparam int CW = $clog2(MAX_PINGS + 1);
    localparam int SW = DEV_W + CW;
    localparam int DW = SW + 8;
    localparam int LW = CW + 15;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GAP  = 4'd1;
    localparam logic [3:0] S_DEV  = 4'd2;
    localparam logic [3:0] S_ACC  = 4'd3;
    localparam logic [3:0] S_END  = 4'd4;
    localparam logic [3:0] S_DJ   = 4'd5;
    localparam logic [3:0] S_DJW  = 4'd6;
    localparam logic [3:0] S_DL   = 4'd7;
    localparam logic [3:0] S_DLW  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]        r_state;
    logic [EXP_W-1:0]  r_exp;
    logic [PCNT_W-1:0] r_pcnt;
    logic              r_loss_en;

    logic              r_rx;
    logic              r_empty;
    logic [TIME_W-1:0] r_t;
    logic [TIME_W-1:0] r_prev;
    logic [TIME_W-1:0] r_dif;
    logic              r_first;
    logic [SW-1:0]     r_sum;
    logic [CW-1:0]     r_devcnt;
    logic [CW-1:0]     r_rcv;
    logic [CW-1:0]     r_slot;
    logic [JIT_W-1:0]  r_jit;
    logic [LOSS_W-1:0] r_loss;

    logic              r_m_valid;
    logic [JIT_W-1:0]  r_m_jit;
    logic [LOSS_W-1:0] r_m_loss;
    logic              r_m_none;

    logic [31:0]       w_cnt_full;
    logic [CW-1:0]     w_cnt;
    logic [CW-1:0]     w_lost;
    logic [LW-1:0]     w_loss_num;
    logic [DW-1:0]     w_jit_num;
    logic [TIME_W-1:0] w_ad_a;
    logic [TIME_W-1:0] w_ad_b;
    logic [TIME_W-1:0] w_ad;
    logic [DEV_W-1:0]  w_sat;
    logic              w_out_free;

    logic              w_div_start;
    logic [DW-1:0]     w_div_num;
    logic [CW-1:0]     w_div_den;
    logic [DW-1:0]     w_div_q;
    t_div_status       w_div_st;

    always_comb begin
        if (r_pcnt == '0) begin
            w_cnt_full = 32'd1;
        end else if (32'(r_pcnt) > 32'(MAX_PINGS)) begin
            w_cnt_full = 32'(MAX_PINGS);
        end else begin
            w_cnt_full = 32'(r_pcnt);
        end
        w_cnt  = w_cnt_full[CW-1:0];
        w_lost = (r_rcv >= w_cnt) ? '0 : (w_cnt - r_rcv);
    end

    assign w_loss_num = (LW'(w_lost) << 14) + (LW'(w_lost) << 13) + (LW'(w_lost) << 10)
                      + LW'(w_cnt >> 1);
    assign w_jit_num  = {r_sum, 8'b0} + DW'(r_devcnt >> 1);

    // shared absolute difference: gap in S_GAP, deviation in S_DEV
    always_comb begin
        if (r_state == S_GAP) begin
            w_ad_a = r_t;
            w_ad_b = r_prev;
        end else begin
            w_ad_a = r_dif;
            w_ad_b = TIME_W'(r_exp);
        end
        w_ad  = (w_ad_a >= w_ad_b) ? (w_ad_a - w_ad_b) : (w_ad_b - w_ad_a);
        w_sat = (w_ad[TIME_W-1:DEV_W] != '0) ? '1 : w_ad[DEV_W-1:0];
    end

    assign w_div_start = ((r_state == S_DJ) && (r_devcnt != '0))
                       || ((r_state == S_DL) && r_loss_en);
    assign w_div_num   = (r_state == S_DJ) ? w_jit_num : DW'(w_loss_num);
    assign w_div_den   = (r_state == S_DJ) ? r_devcnt : w_cnt;
    assign w_out_free  = !r_m_valid || m_axis_tready;

    pjlm_div #(
        .DW (DW),
        .VW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_quotient (w_div_q),
        .o_status   (w_div_st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp     <= RST_EXPECTED_INTERVAL;
            r_pcnt    <= RST_PING_COUNT;
            r_loss_en <= RST_LOSS_ENABLE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EXPECTED_INTERVAL: r_exp     <= i_cfg_data[EXP_W-1:0];
                CFG_PING_COUNT:        r_pcnt    <= i_cfg_data[PCNT_W-1:0];
                CFG_LOSS_ENABLE:       r_loss_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_prev    <= '0;
            r_first   <= 1'b0;
            r_sum     <= '0;
            r_devcnt  <= '0;
            r_rcv     <= '0;
            r_slot    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (m_axis_tready && (r_state != S_OUT)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= S_GAP;
                    end
                end
                S_GAP: begin
                    r_dif <= w_ad;
                    if (!r_rx) begin
                        if (r_first) begin
                            r_prev <= r_prev + TIME_W'(r_exp);
                        end
                        r_slot  <= r_slot + 1'b1;
                        r_state <= S_END;
                    end else if (r_first) begin
                        r_state <= S_DEV;
                    end else begin
                        r_state <= S_ACC;
                    end
                end
                S_DEV: begin
                    r_dif   <= TIME_W'(w_sat);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_first) begin
                        r_sum    <= r_sum + SW'(r_dif[DEV_W-1:0]);
                        r_devcnt <= r_devcnt + 1'b1;
                    end
                    r_prev  <= r_t;
                    r_first <= 1'b1;
                    r_rcv   <= r_rcv + 1'b1;
                    r_slot  <= r_slot + 1'b1;
                    r_state <= S_END;
                end
                S_END: begin
                    r_state <= ((r_slot >= w_cnt) || r_empty) ? S_DJ : S_IDLE;
                end
                S_DJ: begin
                    r_jit   <= '0;
                    r_state <= (r_devcnt != '0) ? S_DJW : S_DL;
                end
                S_DJW: begin
                    if (w_div_st.done) begin
                        r_jit   <= w_div_q[JIT_W-1:0];
                        r_state <= S_DL;
                    end
                end
                S_DL: begin
                    r_loss  <= '0;
                    r_state <= r_loss_en ? S_DLW : S_OUT;
                end
                S_DLW: begin
                    if (w_div_st.done) begin
                        r_loss  <= w_div_q[LOSS_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_jit   <= r_jit;
                        r_m_loss  <= r_loss;
                        r_m_none  <= (r_devcnt == '0);
                        r_prev    <= '0;
                        r_first   <= 1'b0;
                        r_sum     <= '0;
                        r_devcnt  <= '0;
                        r_rcv     <= '0;
                        r_slot    <= '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && s_axis_tvalid) begin
            r_rx    <= s_axis_tuser;
            r_t     <= s_axis_tdata[TIME_W-1:0];
            r_empty <= s_axis_tlast;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, r_m_loss, r_m_jit};
    assign m_axis_tuser  = r_m_none;

endmodule

// ===== src/pjlm_checker.sv =====
module pjlm_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [pjlm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input logic                                 m_axis_tuser
);
    import pjlm_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("slot taken while previous slot still in work");

    a_no_samples_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[JIT_W-1:0] == '0)
        else $error("mean jitter nonzero without samples");

    a_loss_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[JIT_W+LOSS_W-1:JIT_W] <= LOSS_FULL_SCALE
            && m_axis_tdata[OUT_TDATA_W-1] == 1'b0)
        else $error("loss percentage out of range");

endmodule

bind ping_jitter_loss_meter_unit pjlm_checker u_pjlm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
